### rtl/lgb_pkg.sv
// Shared types, widths and constants of the lookahead goal bearing block.
package lgb_pkg;

    // Coordinate and arithmetic widths
    localparam int COORD_WIDTH      = 32;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // difference of two coordinates
    localparam int LW    = CW - 1;          // lookahead
    localparam int SQW   = 2 * DW;          // squared difference
    localparam int SUMW  = SQW + 1;         // sum of two squares
    localparam int LSQW  = 2 * LW;          // squared lookahead
    localparam int NORM_BIT = 48;           // normalize until one magnitude reaches 2^48
    localparam int NW    = NORM_BIT + 1;    // normalized magnitude
    localparam int XW    = NORM_BIT + 5;    // CORDIC x/y with gain and sign
    localparam int ZW    = 32;              // angle accumulator, Q4.28
    localparam int IW    = $clog2(ANGLE_ITERATIONS);
    localparam int AW    = 28;              // atan table entry width
    localparam int BW    = 16;              // bearing, Q3.13
    localparam int MW    = 30;              // clamped angle magnitude
    localparam int FRAC_DROP = 15;          // Q28 -> Q13

    localparam logic signed [ZW-1:0] PI_Q28     = 32'sd843314857;
    localparam logic [MW:0]          ROUND_HALF = (MW+1)'(16384);

    // Configuration register indexes
    localparam logic [1:0] CFG_POSITION_X = 2'd0;
    localparam logic [1:0] CFG_POSITION_Y = 2'd1;
    localparam logic [1:0] CFG_LOOKAHEAD  = 2'd2;

    localparam logic [CW-1:0] POS_X_RESET     = CW'(0);
    localparam logic [CW-1:0] POS_Y_RESET     = CW'(-655360);
    localparam logic [LW-1:0] LOOKAHEAD_RESET = LW'(131072);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_SQUARE,
        ST_COMPARE,
        ST_NORM,
        ST_CORDIC,
        ST_FINISH
    } lgb_state_t;

    typedef struct packed {
        logic capture;
        logic abs_load;
        logic square;
        logic norm_step;
        logic cordic_init;
        logic cordic_step;
        logic load_out;
    } lgb_cmd_t;

    typedef struct packed {
        logic far;
        logic last;
        logic zero;
        logic norm_done;
        logic iter_last;
    } lgb_status_t;

    // Rounded atan(2^-i) in Q28
    function automatic logic [AW-1:0] atan_q28(input logic [4:0] idx);
        logic [AW-1:0] v;
        unique case (idx)
            5'd0:    v = AW'(210828714);
            5'd1:    v = AW'(124459457);
            5'd2:    v = AW'(65760959);
            5'd3:    v = AW'(33381290);
            5'd4:    v = AW'(16755422);
            5'd5:    v = AW'(8385879);
            5'd6:    v = AW'(4193963);
            5'd7:    v = AW'(2097109);
            5'd8:    v = AW'(1048571);
            5'd9:    v = AW'(524287);
            5'd10:   v = AW'(262144);
            5'd11:   v = AW'(131072);
            5'd12:   v = AW'(65536);
            5'd13:   v = AW'(32768);
            5'd14:   v = AW'(16384);
            5'd15:   v = AW'(8192);
            5'd16:   v = AW'(4096);
            5'd17:   v = AW'(2048);
            5'd18:   v = AW'(1024);
            5'd19:   v = AW'(512);
            5'd20:   v = AW'(256);
            5'd21:   v = AW'(128);
            5'd22:   v = AW'(64);
            5'd23:   v = AW'(32);
            default: v = AW'(0);
        endcase
        return v;
    endfunction

endpackage

### rtl/lgb_datapath.sv
// Datapath: configuration, distance check, normalization, CORDIC and result registers.
module lgb_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_index,
    input  logic [lgb_pkg::CW-1:0]          cfg_data,
    input  logic signed [lgb_pkg::CW-1:0]   point_x,
    input  logic signed [lgb_pkg::CW-1:0]   point_y,
    input  logic                            last_point,
    input  lgb_pkg::lgb_cmd_t               cmd,
    output lgb_pkg::lgb_status_t            status,
    output logic signed [lgb_pkg::CW-1:0]   goal_x,
    output logic signed [lgb_pkg::CW-1:0]   goal_y,
    output logic signed [lgb_pkg::BW-1:0]   bearing,
    output logic                            reached_end
);

    logic signed [lgb_pkg::CW-1:0]   pos_x_reg;
    logic signed [lgb_pkg::CW-1:0]   pos_y_reg;
    logic [lgb_pkg::LW-1:0]          lookahead_reg;

    logic signed [lgb_pkg::CW-1:0]   px_reg;
    logic signed [lgb_pkg::CW-1:0]   py_reg;
    logic                            last_reg;
    logic signed [lgb_pkg::DW-1:0]   dx_reg;
    logic signed [lgb_pkg::DW-1:0]   dy_reg;
    logic [lgb_pkg::NW-1:0]          ax_reg;
    logic [lgb_pkg::NW-1:0]          ay_reg;
    logic [lgb_pkg::SQW-1:0]         sqx_reg;
    logic [lgb_pkg::SQW-1:0]         sqy_reg;
    logic [lgb_pkg::LSQW-1:0]        lsq_reg;
    logic signed [lgb_pkg::XW-1:0]   x_reg;
    logic signed [lgb_pkg::XW-1:0]   y_reg;
    logic signed [lgb_pkg::ZW-1:0]   z_reg;
    logic [lgb_pkg::IW-1:0]          iter_reg;
    logic signed [lgb_pkg::CW-1:0]   goal_x_reg;
    logic signed [lgb_pkg::CW-1:0]   goal_y_reg;
    logic signed [lgb_pkg::BW-1:0]   bearing_reg;
    logic                            reached_end_reg;

    logic [lgb_pkg::DW-1:0]          ax_abs;
    logic [lgb_pkg::DW-1:0]          ay_abs;
    logic [lgb_pkg::SUMW-1:0]        dist_sq;
    logic [lgb_pkg::NW-1:0]          mag_or;
    logic signed [lgb_pkg::XW-1:0]   xs;
    logic signed [lgb_pkg::XW-1:0]   ys;
    logic signed [lgb_pkg::ZW-1:0]   atan_step;
    logic signed [lgb_pkg::ZW:0]     m_raw;
    logic [lgb_pkg::MW-1:0]          m_clamp;
    logic [lgb_pkg::MW:0]            m_round;
    logic signed [lgb_pkg::BW-1:0]   mag_q13;
    logic signed [lgb_pkg::BW-1:0]   bearing_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= lgb_pkg::POS_X_RESET;
            pos_y_reg     <= lgb_pkg::POS_Y_RESET;
            lookahead_reg <= lgb_pkg::LOOKAHEAD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lgb_pkg::CFG_POSITION_X: pos_x_reg     <= cfg_data;
                lgb_pkg::CFG_POSITION_Y: pos_y_reg     <= cfg_data;
                lgb_pkg::CFG_LOOKAHEAD:  lookahead_reg <= cfg_data[lgb_pkg::LW-1:0];
                default:                 ;
            endcase
        end
    end

    assign ax_abs = dx_reg[lgb_pkg::DW-1] ? lgb_pkg::DW'(-dx_reg) : lgb_pkg::DW'(dx_reg);
    assign ay_abs = dy_reg[lgb_pkg::DW-1] ? lgb_pkg::DW'(-dy_reg) : lgb_pkg::DW'(dy_reg);

    assign dist_sq = lgb_pkg::SUMW'(sqx_reg) + lgb_pkg::SUMW'(sqy_reg);
    assign mag_or  = ax_reg | ay_reg;

    assign xs        = x_reg >>> iter_reg;
    assign ys        = y_reg >>> iter_reg;
    assign atan_step = signed'(lgb_pkg::ZW'(lgb_pkg::atan_q28(5'(iter_reg))));

    // Mirror into the left half plane, clamp to [0, pi], round to Q13, sign from dy
    always_comb
    begin
        if (dx_reg[lgb_pkg::DW-1])
            m_raw = (lgb_pkg::ZW+1)'(lgb_pkg::PI_Q28) - (lgb_pkg::ZW+1)'(z_reg);
        else
            m_raw = (lgb_pkg::ZW+1)'(z_reg);
        priority if (m_raw < 0)
            m_clamp = '0;
        else if (m_raw > (lgb_pkg::ZW+1)'(lgb_pkg::PI_Q28))
            m_clamp = lgb_pkg::MW'(lgb_pkg::PI_Q28);
        else
            m_clamp = lgb_pkg::MW'(m_raw);
        m_round = (lgb_pkg::MW+1)'(m_clamp) + lgb_pkg::ROUND_HALF;
        mag_q13 = signed'(m_round[lgb_pkg::MW:lgb_pkg::FRAC_DROP]);
        priority if (status.zero)
            bearing_next = '0;
        else if (dy_reg[lgb_pkg::DW-1])
            bearing_next = -mag_q13;
        else
            bearing_next = mag_q13;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            last_reg <= last_point;
            dx_reg   <= lgb_pkg::DW'(point_x) - lgb_pkg::DW'(pos_x_reg);
            dy_reg   <= lgb_pkg::DW'(point_y) - lgb_pkg::DW'(pos_y_reg);
        end
        if (cmd.abs_load)
        begin
            ax_reg <= lgb_pkg::NW'(ax_abs);
            ay_reg <= lgb_pkg::NW'(ay_abs);
        end
        else if (cmd.norm_step)
        begin
            // Coarse step while far below the threshold, then single bits
            if (mag_or[lgb_pkg::NORM_BIT:lgb_pkg::NORM_BIT-8] == '0)
            begin
                ax_reg <= ax_reg << 8;
                ay_reg <= ay_reg << 8;
            end
            else
            begin
                ax_reg <= ax_reg << 1;
                ay_reg <= ay_reg << 1;
            end
        end
        if (cmd.square)
        begin
            sqx_reg <= lgb_pkg::SQW'(ax_reg[lgb_pkg::DW-1:0]) *
                       lgb_pkg::SQW'(ax_reg[lgb_pkg::DW-1:0]);
            sqy_reg <= lgb_pkg::SQW'(ay_reg[lgb_pkg::DW-1:0]) *
                       lgb_pkg::SQW'(ay_reg[lgb_pkg::DW-1:0]);
            lsq_reg <= lgb_pkg::LSQW'(lookahead_reg) * lgb_pkg::LSQW'(lookahead_reg);
        end
        if (cmd.cordic_init)
        begin
            x_reg    <= signed'(lgb_pkg::XW'(ax_reg));
            y_reg    <= signed'(lgb_pkg::XW'(ay_reg));
            z_reg    <= '0;
            iter_reg <= '0;
        end
        else if (cmd.cordic_step)
        begin
            if (!y_reg[lgb_pkg::XW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_step;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_step;
            end
            iter_reg <= iter_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            goal_x_reg      <= px_reg;
            goal_y_reg      <= py_reg;
            bearing_reg     <= bearing_next;
            reached_end_reg <= !status.far;
        end
    end

    assign status.far       = dist_sq >= lgb_pkg::SUMW'(lsq_reg);
    assign status.last      = last_reg;
    assign status.zero      = (ax_reg == '0) && (ay_reg == '0);
    assign status.norm_done = mag_or[lgb_pkg::NORM_BIT];
    assign status.iter_last = iter_reg == lgb_pkg::IW'(lgb_pkg::ANGLE_ITERATIONS - 1);

    assign goal_x      = goal_x_reg;
    assign goal_y      = goal_y_reg;
    assign bearing     = bearing_reg;
    assign reached_end = reached_end_reg;

endmodule

### rtl/lgb_ctrl.sv
// Controller: sequences one point through the datapath and owns the pass and output flags.
module lgb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_stall,
    input  logic                  last_point,
    output logic                  goal_valid,
    input  logic                  goal_stall,
    input  lgb_pkg::lgb_status_t  status,
    output lgb_pkg::lgb_cmd_t     cmd
);

    lgb_pkg::lgb_state_t state_reg;
    lgb_pkg::lgb_state_t state_next;
    logic                answered_reg;
    logic                answered_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgb_pkg::ST_IDLE;
            answered_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            answered_reg  <= answered_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        answered_next = answered_reg;
        cmd           = '0;
        unique case (state_reg)
            lgb_pkg::ST_IDLE:
            begin
                if (point_valid)
                begin
                    cmd.capture = 1'b1;
                    // Goal already sent this pass: drop the point, clear on the last one
                    if (answered_reg)
                    begin
                        if (last_point)
                            answered_next = 1'b0;
                    end
                    else
                        state_next = lgb_pkg::ST_ABS;
                end
            end
            lgb_pkg::ST_ABS:
            begin
                cmd.abs_load = 1'b1;
                state_next   = lgb_pkg::ST_SQUARE;
            end
            lgb_pkg::ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = lgb_pkg::ST_COMPARE;
            end
            lgb_pkg::ST_COMPARE:
            begin
                if (!status.far && !status.last)
                    state_next = lgb_pkg::ST_IDLE;
                else
                begin
                    answered_next = !status.last;
                    state_next    = status.zero ? lgb_pkg::ST_FINISH : lgb_pkg::ST_NORM;
                end
            end
            lgb_pkg::ST_NORM:
            begin
                if (status.norm_done)
                begin
                    cmd.cordic_init = 1'b1;
                    state_next      = lgb_pkg::ST_CORDIC;
                end
                else
                    cmd.norm_step = 1'b1;
            end
            lgb_pkg::ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (status.iter_last)
                    state_next = lgb_pkg::ST_FINISH;
            end
            lgb_pkg::ST_FINISH:
            begin
                // Hold until the output register is free or being emptied
                if (!(out_valid_reg && goal_stall))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = lgb_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lgb_pkg::ST_IDLE;
        endcase
        out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && goal_stall);
    end

    assign point_stall = state_reg != lgb_pkg::ST_IDLE;
    assign goal_valid  = out_valid_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && goal_stall))
        else $error("result register loaded while a result is stalled");

    // A point arriving after the goal never starts the distance check
    a_drop_after_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lgb_pkg::ST_IDLE && point_valid && answered_reg)
        |=> state_reg == lgb_pkg::ST_IDLE)
        else $error("point processed after goal was already sent");

    // A new result only comes out of the finish step
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == lgb_pkg::ST_FINISH)
        else $error("result valid raised outside the finish step");

    // A result always ends the pass or marks it answered
    a_answered_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (answered_reg != status.last))
        else $error("answered flag inconsistent with emitted result");

endmodule

### rtl/lookahead_goal_bearing.sv
// Top level of the lookahead goal bearing block: controller plus datapath.
//
//  channel   direction  handshake              payload
//  point     in         point_valid/stall      point_x, point_y, last_point
//  goal      out        goal_valid/stall       goal_x, goal_y, bearing, reached_end
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// No-result point: capture, abs, square, compare; a dropped point is only captured.
// Goal point: the same steps, then N normalize steps (3 to 13) of the shared normalizer,
// 16 CORDIC iterations and the finish step; a goal at the position skips normalize and CORDIC.
// Reset clears the controller, the pass flag and the output valid; config
// registers return to position (0, -10.0) and lookahead 2.0.
// A stalled goal holds the next result in the finish step; configuration is always ready.
module lookahead_goal_bearing (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            point_valid,
    output logic                            point_stall,
    input  logic signed [lgb_pkg::CW-1:0]   point_x,
    input  logic signed [lgb_pkg::CW-1:0]   point_y,
    input  logic                            last_point,
    output logic                            goal_valid,
    input  logic                            goal_stall,
    output logic signed [lgb_pkg::CW-1:0]   goal_x,
    output logic signed [lgb_pkg::CW-1:0]   goal_y,
    output logic signed [lgb_pkg::BW-1:0]   bearing,
    output logic                            reached_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [lgb_pkg::CW-1:0]          cfg_data
);

    lgb_pkg::lgb_cmd_t    cmd;
    lgb_pkg::lgb_status_t status;

    assign cfg_ready = 1'b1;

    lgb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .last_point  (last_point),
        .goal_valid  (goal_valid),
        .goal_stall  (goal_stall),
        .status      (status),
        .cmd         (cmd)
    );

    lgb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point),
        .cmd         (cmd),
        .status      (status),
        .goal_x      (goal_x),
        .goal_y      (goal_y),
        .bearing     (bearing),
        .reached_end (reached_end)
    );

endmodule
